FILE: rtl/toml_string_lexer_assert.svh
// Assertion macros used by the lexer's top-level RTL file.
// TSL_ASSERT_IMP checks a consequence in the same cycle, TSL_ASSERT_NXT in the next cycle.
`ifndef TOML_STRING_LEXER_ASSERT_SVH
`define TOML_STRING_LEXER_ASSERT_SVH

`ifndef ASSERT_OFF

`define TSL_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

`define TSL_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define TSL_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)

`define TSL_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

FILE: rtl/tsl_pkg.sv
package tsl_pkg;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [20:0] code_point;
		logic        last_of_item;
	} result_t;

	// Up to three results produced by one request, in order from index 0.
	typedef struct packed {
		logic [1:0]        cnt;
		result_t [2:0]     res;
	} burst_t;

	localparam logic [1:0] KIND_CP  = 2'd0;
	localparam logic [1:0] KIND_STR = 2'd1;
	localparam logic [1:0] KIND_KEY = 2'd2;
	localparam logic [1:0] KIND_BAD = 2'd3;

	localparam logic [20:0] MAX_CP   = 21'h10ffff;
	localparam logic [20:0] CODE_SAT = 21'h1fffff;
	localparam logic [20:0] SURR_LO  = 21'h00d800;
	localparam logic [20:0] SURR_HI  = 21'h00dfff;
	localparam logic [16:0] MIN_CP4  = 17'h10000;
	localparam logic [16:0] MIN_CP3  = 17'h00800;
	localparam logic [16:0] MIN_CP2  = 17'h00080;

	// Length class of a UTF-8 sequence in progress.
	localparam logic [1:0] SLC_NONE = 2'd0;
	localparam logic [1:0] SLC_FOUR = 2'd1;
	localparam logic [1:0] SLC_THREE = 2'd2;
	localparam logic [1:0] SLC_TWO  = 2'd3;

	typedef enum logic [3:0] {
		CL_OTHER  = 4'd0,
		CL_LEAD4  = 4'd1,
		CL_LEAD3  = 4'd2,
		CL_LEAD2  = 4'd3,
		CL_CONT   = 4'd4,
		CL_PRINT  = 4'd5,
		CL_HEX    = 4'd6,
		CL_BIGU   = 4'd7,
		CL_SMALLU = 4'd8,
		CL_BLANK  = 4'd9,
		CL_BSL    = 4'd10,
		CL_APOS   = 4'd11,
		CL_QUOT   = 4'd12,
		CL_EOL    = 4'd13
	} cls_t;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_LEAD   = 3'd1,
		ACT_FINISH = 3'd2,
		ACT_BYTE   = 3'd3,
		ACT_DROP2  = 3'd4,
		ACT_ESC    = 3'd5,
		ACT_HEXD   = 3'd6,
		ACT_HEXEND = 3'd7
	} act_t;

	// B = basic, MB/M = multiline basic, L = literal, ML = multiline literal.
	typedef enum logic [5:0] {
		ST_START    = 6'd1,
		ST_B_OPEN   = 6'd2,
		ST_B_EMPTY  = 6'd3,
		ST_MB_OPEN  = 6'd4,
		ST_MB_Q1    = 6'd5,
		ST_MB_Q2    = 6'd6,
		ST_CLOSED   = 6'd7,
		ST_B_END    = 6'd8,
		ST_B_CONT3  = 6'd9,
		ST_B_CONT2  = 6'd10,
		ST_B_CONT1  = 6'd11,
		ST_B_BODY   = 6'd12,
		ST_B_ESC    = 6'd13,
		ST_B_HEX8   = 6'd14,
		ST_B_HEX7   = 6'd15,
		ST_B_HEX6   = 6'd16,
		ST_B_HEX5   = 6'd17,
		ST_B_HEX4   = 6'd18,
		ST_B_HEX3   = 6'd19,
		ST_B_HEX2   = 6'd20,
		ST_B_HEX1   = 6'd21,
		ST_M_CONT3  = 6'd22,
		ST_M_CONT2  = 6'd23,
		ST_M_CONT1  = 6'd24,
		ST_M_BODY   = 6'd25,
		ST_M_ESC    = 6'd26,
		ST_M_HEX8   = 6'd27,
		ST_M_HEX7   = 6'd28,
		ST_M_HEX6   = 6'd29,
		ST_M_HEX5   = 6'd30,
		ST_M_HEX4   = 6'd31,
		ST_M_HEX3   = 6'd32,
		ST_M_HEX2   = 6'd33,
		ST_M_HEX1   = 6'd34,
		ST_M_TRIM   = 6'd35,
		ST_L_OPEN   = 6'd36,
		ST_L_EMPTY  = 6'd37,
		ST_ML_OPEN  = 6'd38,
		ST_ML_Q1    = 6'd39,
		ST_ML_Q2    = 6'd40,
		ST_L_CONT3  = 6'd41,
		ST_L_CONT2  = 6'd42,
		ST_L_CONT1  = 6'd43,
		ST_L_BODY   = 6'd44,
		ST_ML_CONT3 = 6'd45,
		ST_ML_CONT2 = 6'd46,
		ST_ML_CONT1 = 6'd47,
		ST_ML_BODY  = 6'd48
	} tsl_state_t;

endpackage

FILE: rtl/tsl_lexer.sv
module tsl_lexer
	import tsl_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   fire,
	input  item_t  item,
	output burst_t burst
);

	tsl_state_t  st_q, st_d, nxt;
	logic [20:0] partial_q, partial_d;
	logic [1:0]  slc_q, slc_d;
	logic [1:0]  held_q, held_d;

	logic [7:0]  b;
	cls_t        cls;
	act_t        act;
	logic        mv_ok;
	logic        is_ascii, is_asciiln, is_lead;
	logic [5:0]  lead_ofs;

	logic [26:0] fin_v;
	logic [16:0] bound;
	logic [20:0] hex_v;
	logic [20:0] v;
	logic        emit, bad;
	logic [1:0]  nq;
	logic [20:0] quote_cp;
	logic [1:0]  end_kind;

	function automatic cls_t classify(logic [7:0] x);
		cls_t c;
		if (x >= 8'hf0 && x <= 8'hf7) c = CL_LEAD4;
		else if (x >= 8'he0 && x <= 8'hef) c = CL_LEAD3;
		else if (x >= 8'hc0 && x <= 8'hdf) c = CL_LEAD2;
		else if (x >= 8'h80 && x <= 8'hbf) c = CL_CONT;
		else if (x == 8'h09 || x == 8'h20) c = CL_BLANK;
		else if (x == 8'h0d || x == 8'h0a) c = CL_EOL;
		else if (x == 8'h5c) c = CL_BSL;
		else if (x == 8'h27) c = CL_APOS;
		else if (x == 8'h22) c = CL_QUOT;
		else if (x == 8'h55) c = CL_BIGU;
		else if (x == 8'h75) c = CL_SMALLU;
		else if ((x >= 8'h30 && x <= 8'h39) || (x >= 8'h61 && x <= 8'h66)
			|| (x >= 8'h41 && x <= 8'h46)) c = CL_HEX;
		else if (x >= 8'h21 && x <= 8'h7e) c = CL_PRINT;
		else c = CL_OTHER;
		return c;
	endfunction

	// Letters a-f and A-F both have 1..6 in the low nibble.
	function automatic logic [3:0] digit_of(logic [7:0] x);
		logic [3:0] d;
		if (x >= 8'h30 && x <= 8'h39) d = x[3:0];
		else if ((x >= 8'h61 && x <= 8'h66) || (x >= 8'h41 && x <= 8'h46))
			d = x[3:0] + 4'd9;
		else d = 4'd0;
		return d;
	endfunction

	// Values past the code space saturate so that they stay out of range.
	function automatic logic [20:0] grow_hex(logic [20:0] acc, logic [7:0] x);
		logic [24:0] r;
		r = {acc, 4'h0} + {21'd0, digit_of(x)};
		return (r > {4'd0, MAX_CP}) ? CODE_SAT : r[20:0];
	endfunction

	function automatic result_t mk_cp(logic [20:0] cp);
		result_t r;
		r.result_kind  = KIND_CP;
		r.code_point   = cp;
		r.last_of_item = 1'b0;
		return r;
	endfunction

	assign b          = item.byte_in;
	assign cls        = item.end_of_text ? CL_OTHER : classify(item.byte_in);
	assign is_ascii   = (cls >= CL_PRINT) && (cls <= CL_QUOT);
	assign is_asciiln = is_ascii || (cls == CL_EOL);
	assign is_lead    = (cls == CL_LEAD4) || (cls == CL_LEAD3) || (cls == CL_LEAD2);
	assign lead_ofs   = (cls == CL_LEAD4) ? 6'd0 : (cls == CL_LEAD3) ? 6'd1 : 6'd2;

	// Next state and action.
	always_comb begin
		mv_ok = 1'b1;
		nxt   = ST_START;
		act   = ACT_NONE;
		unique case (st_q) inside
			ST_START: begin
				if (cls == CL_QUOT) nxt = ST_B_OPEN;
				else if (cls == CL_APOS) nxt = ST_L_OPEN;
				else mv_ok = 1'b0;
			end
			ST_B_OPEN, ST_B_BODY: begin
				if (is_lead) begin
					act = ACT_LEAD;
					nxt = tsl_state_t'(ST_B_CONT3 + lead_ofs);
				end else if (cls == CL_BSL) begin
					nxt = ST_B_ESC;
				end else if (cls == CL_QUOT) begin
					nxt = (st_q == ST_B_OPEN) ? ST_B_EMPTY : ST_B_END;
				end else if (is_ascii) begin
					act = ACT_BYTE;
					nxt = ST_B_BODY;
				end else begin
					mv_ok = 1'b0;
				end
			end
			ST_B_EMPTY: begin
				if (cls == CL_QUOT) nxt = ST_MB_OPEN;
				else mv_ok = 1'b0;
			end
			ST_MB_OPEN, ST_MB_Q1, ST_MB_Q2, ST_M_BODY, ST_M_TRIM: begin
				if (is_lead) begin
					act = ACT_LEAD;
					nxt = tsl_state_t'(ST_M_CONT3 + lead_ofs);
				end else if (cls == CL_BSL) begin
					nxt = ST_M_ESC;
				end else if (cls == CL_QUOT) begin
					if (st_q == ST_MB_Q2) begin
						act = ACT_DROP2;
						nxt = ST_CLOSED;
					end else begin
						act = ACT_BYTE;
						nxt = (st_q == ST_MB_Q1) ? ST_MB_Q2 : ST_MB_Q1;
					end
				end else if (st_q == ST_MB_OPEN && cls == CL_EOL) begin
					nxt = ST_M_BODY;
				end else if (st_q == ST_M_TRIM && (cls == CL_BLANK || cls == CL_EOL)) begin
					nxt = ST_M_TRIM;
				end else if (is_asciiln) begin
					act = ACT_BYTE;
					nxt = ST_M_BODY;
				end else begin
					mv_ok = 1'b0;
				end
			end
			ST_B_CONT3, ST_B_CONT2, ST_M_CONT3, ST_M_CONT2,
			ST_L_CONT3, ST_L_CONT2, ST_ML_CONT3, ST_ML_CONT2: begin
				if (cls == CL_CONT) begin
					act = ACT_LEAD;
					nxt = tsl_state_t'(st_q + 6'd1);
				end else begin
					mv_ok = 1'b0;
				end
			end
			// The last continuation byte leads back to the body state just above.
			ST_B_CONT1, ST_M_CONT1, ST_L_CONT1, ST_ML_CONT1: begin
				if (cls == CL_CONT) begin
					act = ACT_FINISH;
					nxt = tsl_state_t'(st_q + 6'd1);
				end else begin
					mv_ok = 1'b0;
				end
			end
			ST_B_ESC, ST_M_ESC: begin
				if (cls == CL_BIGU) begin
					nxt = tsl_state_t'(st_q + 6'd1);
				end else if (cls == CL_SMALLU) begin
					nxt = tsl_state_t'(st_q + 6'd5);
				end else if (st_q == ST_M_ESC && cls == CL_EOL) begin
					nxt = ST_M_TRIM;
				end else if (is_ascii) begin
					act = ACT_ESC;
					nxt = (st_q == ST_B_ESC) ? ST_B_BODY : ST_M_BODY;
				end else begin
					mv_ok = 1'b0;
				end
			end
			ST_B_HEX8, ST_B_HEX7, ST_B_HEX6, ST_B_HEX5, ST_B_HEX4, ST_B_HEX3, ST_B_HEX2,
			ST_M_HEX8, ST_M_HEX7, ST_M_HEX6, ST_M_HEX5, ST_M_HEX4, ST_M_HEX3,
			ST_M_HEX2: begin
				if (cls == CL_HEX) begin
					act = ACT_HEXD;
					nxt = tsl_state_t'(st_q + 6'd1);
				end else begin
					mv_ok = 1'b0;
				end
			end
			ST_B_HEX1, ST_M_HEX1: begin
				if (cls == CL_HEX) begin
					act = ACT_HEXEND;
					nxt = (st_q == ST_B_HEX1) ? ST_B_BODY : ST_M_BODY;
				end else begin
					mv_ok = 1'b0;
				end
			end
			ST_L_OPEN, ST_L_BODY: begin
				if (is_lead) begin
					act = ACT_LEAD;
					nxt = tsl_state_t'(ST_L_CONT3 + lead_ofs);
				end else if (cls == CL_APOS) begin
					nxt = (st_q == ST_L_OPEN) ? ST_L_EMPTY : ST_CLOSED;
				end else if (is_ascii) begin
					act = ACT_BYTE;
					nxt = ST_L_BODY;
				end else begin
					mv_ok = 1'b0;
				end
			end
			ST_L_EMPTY: begin
				if (cls == CL_APOS) nxt = ST_ML_OPEN;
				else mv_ok = 1'b0;
			end
			ST_ML_OPEN, ST_ML_Q1, ST_ML_Q2, ST_ML_BODY: begin
				if (is_lead) begin
					act = ACT_LEAD;
					nxt = tsl_state_t'(ST_ML_CONT3 + lead_ofs);
				end else if (cls == CL_APOS) begin
					if (st_q == ST_ML_Q2) begin
						act = ACT_DROP2;
						nxt = ST_CLOSED;
					end else begin
						act = ACT_BYTE;
						nxt = (st_q == ST_ML_Q1) ? ST_ML_Q2 : ST_ML_Q1;
					end
				end else if (st_q == ST_ML_OPEN && cls == CL_EOL) begin
					nxt = ST_ML_BODY;
				end else if (is_asciiln) begin
					act = ACT_BYTE;
					nxt = ST_ML_BODY;
				end else begin
					mv_ok = 1'b0;
				end
			end
			default: begin
				mv_ok = 1'b0;
			end
		endcase
	end

	assign fin_v = {partial_q, b[5:0]};
	assign hex_v = grow_hex(partial_q, b);
	assign quote_cp = (st_q == ST_ML_Q1 || st_q == ST_ML_Q2) ? 21'h000027 : 21'h000022;

	always_comb begin
		unique case (slc_q)
			SLC_FOUR:  bound = MIN_CP4;
			SLC_THREE: bound = MIN_CP3;
			SLC_TWO:   bound = MIN_CP2;
			default:   bound = 17'd0;
		endcase
	end

	always_comb begin
		unique case (st_q) inside
			ST_B_EMPTY, ST_CLOSED, ST_L_EMPTY: end_kind = KIND_STR;
			ST_B_END:                          end_kind = KIND_KEY;
			default:                           end_kind = KIND_BAD;
		endcase
	end

	// Register updates and results.
	always_comb begin
		st_d      = st_q;
		partial_d = partial_q;
		slc_d     = slc_q;
		held_d    = held_q;
		v         = 21'd0;
		emit      = 1'b0;
		bad       = 1'b0;
		nq        = 2'd0;
		burst     = '0;

		unique case (act)
			ACT_LEAD: begin
				if (cls == CL_LEAD4) begin
					partial_d = {18'd0, b[2:0]};
					slc_d     = SLC_FOUR;
				end else if (cls == CL_LEAD3) begin
					partial_d = {17'd0, b[3:0]};
					slc_d     = SLC_THREE;
				end else if (cls == CL_LEAD2) begin
					partial_d = {16'd0, b[4:0]};
					slc_d     = SLC_TWO;
				end else begin
					partial_d = {partial_q[14:0], b[5:0]};
				end
			end
			ACT_FINISH: begin
				v = fin_v[20:0];
				if (fin_v < {10'd0, bound} || fin_v > {6'd0, MAX_CP}
					|| (fin_v >= {6'd0, SURR_LO} && fin_v <= {6'd0, SURR_HI})) bad = 1'b1;
				else emit = 1'b1;
				partial_d = 21'd0;
			end
			ACT_BYTE: begin
				v    = {13'd0, b};
				emit = 1'b1;
			end
			ACT_DROP2: begin
				held_d = 2'd0;
			end
			ACT_ESC: begin
				emit = 1'b1;
				unique case (b)
					8'h62:   v = 21'h08;
					8'h74:   v = 21'h09;
					8'h6e:   v = 21'h0a;
					8'h66:   v = 21'h0c;
					8'h72:   v = 21'h0d;
					8'h5c:   v = 21'h5c;
					8'h22:   v = 21'h22;
					default: begin
						emit = 1'b0;
						bad  = 1'b1;
					end
				endcase
			end
			ACT_HEXD: begin
				partial_d = hex_v;
			end
			ACT_HEXEND: begin
				v = hex_v;
				if (hex_v > MAX_CP || (hex_v >= SURR_LO && hex_v <= SURR_HI)) bad = 1'b1;
				else emit = 1'b1;
				partial_d = 21'd0;
			end
			default: begin
			end
		endcase

		if (!mv_ok || bad) begin
			// The string ends or fails here; start over at the next request.
			burst.cnt                     = 2'd1;
			burst.res[0].result_kind      = mv_ok ? KIND_BAD : end_kind;
			burst.res[0].code_point       = 21'd0;
			burst.res[0].last_of_item     = 1'b1;
			st_d      = ST_START;
			partial_d = 21'd0;
			slc_d     = SLC_FOUR;
			held_d    = 2'd0;
		end else begin
			st_d = nxt;
			if (act == ACT_BYTE && (nxt == ST_MB_Q1 || nxt == ST_MB_Q2
				|| nxt == ST_ML_Q1 || nxt == ST_ML_Q2)) begin
				held_d = held_q + 2'd1;
			end else begin
				if (held_q != 2'd0 && act != ACT_DROP2) begin
					nq     = (held_q >= 2'd2) ? 2'd2 : 2'd1;
					held_d = 2'd0;
				end
				if (nq != 2'd0) burst.res[0] = mk_cp(quote_cp);
				if (nq == 2'd2) burst.res[1] = mk_cp(quote_cp);
				if (emit) burst.res[nq] = mk_cp(v);
				burst.cnt = nq + {1'b0, emit};
				if (burst.cnt != 2'd0) burst.res[burst.cnt - 2'd1].last_of_item = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_START;
			partial_q <= 21'd0;
			slc_q     <= SLC_FOUR;
			held_q    <= 2'd0;
		end else if (fire) begin
			st_q      <= st_d;
			partial_q <= partial_d;
			slc_q     <= slc_d;
			held_q    <= held_d;
		end
	end

endmodule

FILE: rtl/tsl_res_buf.sv
module tsl_res_buf
	import tsl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  burst_t  burst,
	output logic    free,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res_data
);

	logic [1:0]    n_q;
	result_t [2:0] slot_q;
	logic          take;

	assign res_valid = (n_q != 2'd0);
	assign res_data  = slot_q[0];
	assign take      = res_valid && res_ready;
	// A new burst may land when the buffer is empty or drains in this cycle.
	assign free      = (n_q == 2'd0) || (n_q == 2'd1 && res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 2'd0;
		end else if (load) begin
			n_q <= burst.cnt;
		end else if (take) begin
			n_q <= n_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= burst.res;
		end else if (take) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

FILE: rtl/toml_string_lexer.sv
// TOML string literal lexer.
// The request channel (req_valid, req_ready, req_data) takes one source byte per
// request, or an end-of-text mark. The result channel (res_valid, res_ready,
// res_data) returns decoded code points, string done (plain or key-capable) and
// invalid, with last_of_item set on the final result of each request that yields any.
// A request is registered on acceptance, lexed once the result buffer is free, and
// its results are loaded into a three-entry result buffer; res_valid is registered
// and rises once a request that yields results has been loaded. One request per
// cycle is sustained while every request yields at most one result and res_ready
// stays high. A request that flushes held quotes yields up to three results, and
// the buffer hands them out one per cycle while res_ready is high; the next
// request waits in the input register until the last of them is taken.
// When the receiver stalls, the buffer holds its results and the input register
// fills, after which req_ready drops.
// Reset clears the input register's valid flag, empties the buffer and puts the
// lexer back in its start state, ready for the opening quote of a new string.
`include "toml_string_lexer_assert.svh"

module toml_string_lexer
	import tsl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  item_t   req_data,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res_data
);

	logic   v_s1;
	item_t  item_s1;
	logic   free;
	logic   fire;
	burst_t burst;
	logic   res_end;
	logic   empty_load;
	logic   res_more;

	assign fire      = v_s1 && free;
	assign req_ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req_data;
		end
	end

	tsl_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.burst  (burst)
	);

	tsl_res_buf u_res_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.burst     (burst),
		.free      (free),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	assign res_end    = res_valid && (res_data.result_kind != KIND_CP);
	assign empty_load = fire && (burst.cnt == 2'd0);
	assign res_more   = res_valid && res_ready && !res_data.last_of_item;

	`TSL_ASSERT_IMP(a_end_is_last, clk, arst_n, res_end, res_data.last_of_item, "end not last")
	`TSL_ASSERT_NXT(a_empty_burst, clk, arst_n, empty_load, !res_valid, "buffer not empty")
	`TSL_ASSERT_NXT(a_burst_contig, clk, arst_n, res_more, res_valid, "results split")

endmodule
